// ===== rtl/core/imx_pkg.sv =====
// Shared widths, constants and pipeline types for the 3x3 matrix inverter.
`default_nettype none
package imx_pkg;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int N_ENT     = 9;
  localparam int N_COL     = 3;
  // cofactor: difference of two 32x32 products
  localparam int CW  = 2 * DATA_W + 1;
  // determinant: three 32 x CW products summed
  localparam int DW  = DATA_W + CW + 2;
  localparam int DMW = DW - 1;
  // quotient bits: the output magnitude plus one overflow bit
  localparam int QW  = DATA_W + 1;
  localparam int RW  = DMW + QW - 1;
  localparam int N_DIV_STEPS = QW;

  localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MIN_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic [N_ENT-1:0][DATA_W-1:0] mat_t;
  typedef logic [N_ENT-1:0][CW-1:0]     cof_t;
  typedef logic [N_COL-1:0][DATA_W-1:0] row_t;

  typedef struct packed {
    logic [N_ENT-1:0][RW-1:0] rem;
    logic [N_ENT-1:0][QW-1:0] quo;
    logic [N_ENT-1:0]         neg;
    logic [RW-1:0]            den;
    logic                     sing;
  } div_t;
endpackage
`default_nettype wire

// ===== rtl/core/imx_cofactor.sv =====
// Two stages: 2x2 minor products, then signed cofactors.
`default_nettype none
module imx_cofactor import imx_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire mat_t in_mat,
  output logic      cof_valid,
  output cof_t      cof,
  output row_t      arow
);
  logic signed [2*DATA_W-1:0] p_r [N_ENT];
  logic signed [2*DATA_W-1:0] q_r [N_ENT];
  logic signed [2*DATA_W-1:0] p_nxt [N_ENT];
  logic signed [2*DATA_W-1:0] q_nxt [N_ENT];
  row_t arow1_r, arow_r;
  cof_t cof_r, cof_nxt;
  logic v1_r, v2_r;

  always_comb begin
    int r, c, r1, r2, c1, c2;
    logic signed [DATA_W-1:0] x1, x2, y1, y2;
    for (int e = 0; e < N_ENT; e++) begin
      r  = e / 3;
      c  = e % 3;
      r1 = (r == 0) ? 1 : 0;
      r2 = (r == 2) ? 1 : 2;
      c1 = (c == 0) ? 1 : 0;
      c2 = (c == 2) ? 1 : 2;
      x1 = in_mat[r1*3+c1];
      x2 = in_mat[r2*3+c2];
      y1 = in_mat[r1*3+c2];
      y2 = in_mat[r2*3+c1];
      p_nxt[e] = x1 * x2;
      q_nxt[e] = y1 * y2;
    end
  end

  always_comb begin
    logic signed [CW-1:0] d;
    for (int e = 0; e < N_ENT; e++) begin
      d = CW'(p_r[e]) - CW'(q_r[e]);
      // odd row+col positions take a minus sign
      cof_nxt[e] = ((e % 2) == 1) ? -d : d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r     <= p_nxt;
      q_r     <= q_nxt;
      arow1_r <= in_mat[N_COL-1:0];
      cof_r   <= cof_nxt;
      arow_r  <= arow1_r;
    end
  end

  assign cof_valid = v2_r;
  assign cof       = cof_r;
  assign arow      = arow_r;
endmodule
`default_nettype wire

// ===== rtl/core/imx_det.sv =====
// Determinant by row-0 expansion, adjugate magnitudes, divider setup.
`default_nettype none
module imx_det import imx_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic cof_valid,
  input  wire cof_t cof,
  input  wire row_t arow,
  output logic      div_valid,
  output div_t      div_d
);
  logic signed [CW-1:0] pl_r [N_COL];
  logic signed [CW-1:0] ph_r [N_COL];
  logic signed [CW-1:0] pl_nxt [N_COL];
  logic signed [CW-1:0] ph_nxt [N_COL];
  logic signed [DW-1:0] t_r [N_COL];
  logic signed [DW-1:0] t_nxt [N_COL];
  logic signed [DW-1:0] det_r, det_nxt;
  cof_t cof3_r, cof4_r;
  logic [N_ENT-1:0][CW-1:0] amag_r, amag_nxt;
  logic [N_ENT-1:0]         aneg_r, aneg_nxt;
  div_t div_r, div_nxt;
  logic v3_r, v4_r, v5_r, v6_r;

  // stage 3: split each cofactor so no product exceeds 32 x 33
  always_comb begin
    logic signed [DATA_W-1:0] av;
    logic signed [DATA_W:0]   lo_s, hi_s;
    for (int c = 0; c < N_COL; c++) begin
      av   = arow[c];
      lo_s = {1'b0, cof[c][DATA_W-1:0]};
      hi_s = cof[c][CW-1:DATA_W];
      pl_nxt[c] = av * lo_s;
      ph_nxt[c] = av * hi_s;
    end
  end

  // stage 4: recombine partial products
  always_comb begin
    for (int c = 0; c < N_COL; c++) begin
      t_nxt[c] = (DW'(ph_r[c]) <<< DATA_W) + DW'(pl_r[c]);
    end
  end

  // stage 5: determinant sum, adjugate magnitudes (transposed cofactors)
  always_comb begin
    logic signed [CW-1:0] cv;
    det_nxt = t_r[0] + t_r[1] + t_r[2];
    for (int e = 0; e < N_ENT; e++) begin
      cv = cof4_r[(e % 3) * 3 + (e / 3)];
      aneg_nxt[e] = cv[CW-1];
      amag_nxt[e] = cv[CW-1] ? CW'(-cv) : CW'(cv);
    end
  end

  // stage 6: divider operands
  always_comb begin
    logic          dneg;
    logic [DW-1:0] dabs;
    dneg = det_r[DW-1];
    dabs = dneg ? DW'(-det_r) : DW'(det_r);
    div_nxt.den  = RW'(dabs[DMW-1:0]) << (QW - 1);
    div_nxt.sing = (det_r == '0);
    for (int e = 0; e < N_ENT; e++) begin
      div_nxt.rem[e] = RW'(amag_r[e]) << (2 * FRAC_BITS);
      div_nxt.quo[e] = '0;
      div_nxt.neg[e] = aneg_r[e] ^ dneg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v3_r <= cof_valid;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r   <= pl_nxt;
      ph_r   <= ph_nxt;
      cof3_r <= cof;
      t_r    <= t_nxt;
      cof4_r <= cof3_r;
      det_r  <= det_nxt;
      amag_r <= amag_nxt;
      aneg_r <= aneg_nxt;
      div_r  <= div_nxt;
    end
  end

  assign div_valid = v6_r;
  assign div_d     = div_r;
endmodule
`default_nettype wire

// ===== rtl/core/imx_div_step.sv =====
// One restoring-division stage for all nine entries.
`default_nettype none
module imx_div_step import imx_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire div_t in_d,
  output logic      out_valid,
  output div_t      out_d
);
  div_t d_r, d_nxt;
  logic v_r;

  always_comb begin
    d_nxt     = in_d;
    d_nxt.den = in_d.den >> 1;
    for (int e = 0; e < N_ENT; e++) begin
      if (in_d.rem[e] >= in_d.den) begin
        d_nxt.rem[e] = in_d.rem[e] - in_d.den;
        d_nxt.quo[e] = {in_d.quo[e][QW-2:0], 1'b1};
      end else begin
        d_nxt.quo[e] = {in_d.quo[e][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_d     = d_r;
endmodule
`default_nettype wire

// ===== rtl/core/matrix_inverse_3x3_top.sv =====
// Top level of the pipelined 3x3 fixed-point matrix inverter.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_ready  | in_r0c0 .. in_r2c2, signed Q16.16
//  out     | out_valid/ out_ready | out_r0c0 .. out_r2c2, out_singular,
//          |                      | out_saturated
//
// Accepts one matrix request per cycle while in_ready is high; the pipe has 2
// cofactor stages, 4 determinant/setup stages, 33 divider stages (one quotient
// bit each, the top bit flags overflow), and the output register.
// All stages share one enable: the pipe moves whenever the output register
// is empty or being taken, so a stall freezes everything in place.
// Reset clears only the valid bits.
`default_nettype none
module matrix_inverse_3x3_top import imx_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_r0c0,
  input  wire logic signed [31:0] in_r0c1,
  input  wire logic signed [31:0] in_r0c2,
  input  wire logic signed [31:0] in_r1c0,
  input  wire logic signed [31:0] in_r1c1,
  input  wire logic signed [31:0] in_r1c2,
  input  wire logic signed [31:0] in_r2c0,
  input  wire logic signed [31:0] in_r2c1,
  input  wire logic signed [31:0] in_r2c2,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_r0c0,
  output logic signed [31:0]      out_r0c1,
  output logic signed [31:0]      out_r0c2,
  output logic signed [31:0]      out_r1c0,
  output logic signed [31:0]      out_r1c1,
  output logic signed [31:0]      out_r1c2,
  output logic signed [31:0]      out_r2c0,
  output logic signed [31:0]      out_r2c1,
  output logic signed [31:0]      out_r2c2,
  output logic                    out_singular,
  output logic                    out_saturated
);
  logic en;
  mat_t in_mat;
  logic cof_valid;
  cof_t cof;
  row_t arow;
  logic div_v [N_DIV_STEPS+1];
  div_t div_d [N_DIV_STEPS+1];
  logic out_valid_r;
  mat_t out_mat_r, out_mat_nxt;
  logic sing_r, sing_nxt, sat_r, sat_nxt;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign in_mat   = {in_r2c2, in_r2c1, in_r2c0, in_r1c2, in_r1c1, in_r1c0,
                     in_r0c2, in_r0c1, in_r0c0};

  imx_cofactor u_cof (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_valid), .in_mat(in_mat),
    .cof_valid(cof_valid), .cof(cof), .arow(arow)
  );

  imx_det u_det (
    .clk(clk), .rst_n(rst_n), .en(en),
    .cof_valid(cof_valid), .cof(cof), .arow(arow),
    .div_valid(div_v[0]), .div_d(div_d[0])
  );

  for (genvar k = 0; k < N_DIV_STEPS; k++) begin : g_div
    imx_div_step u_step (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(div_v[k]), .in_d(div_d[k]),
      .out_valid(div_v[k+1]), .out_d(div_d[k+1])
    );
  end

  // sign, saturation and the singular override
  always_comb begin
    logic [QW-1:0]     q;
    logic [DATA_W-1:0] m;
    logic              ng, clip;
    sat_nxt  = 1'b0;
    sing_nxt = div_d[N_DIV_STEPS].sing;
    for (int e = 0; e < N_ENT; e++) begin
      q    = div_d[N_DIV_STEPS].quo[e];
      m    = q[DATA_W-1:0];
      ng   = div_d[N_DIV_STEPS].neg[e];
      clip = q[QW-1] || (!ng && m[DATA_W-1]) || (ng && (m > MIN_NEG));
      if (sing_nxt) begin
        out_mat_nxt[e] = '0;
      end else if (clip) begin
        out_mat_nxt[e] = ng ? MIN_NEG : MAX_POS;
        sat_nxt = 1'b1;
      end else begin
        out_mat_nxt[e] = ng ? -m : m;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_v[N_DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_mat_r <= out_mat_nxt;
      sing_r    <= sing_nxt;
      sat_r     <= sat_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_r0c0      = out_mat_r[0];
  assign out_r0c1      = out_mat_r[1];
  assign out_r0c2      = out_mat_r[2];
  assign out_r1c0      = out_mat_r[3];
  assign out_r1c1      = out_mat_r[4];
  assign out_r1c2      = out_mat_r[5];
  assign out_r2c0      = out_mat_r[6];
  assign out_r2c1      = out_mat_r[7];
  assign out_r2c2      = out_mat_r[8];
  assign out_singular  = sing_r;
  assign out_saturated = sat_r;
endmodule
`default_nettype wire
